### hdl/triangle_area_heron_macros.svh
// Assertion macros shared by the triangle area pipeline
`ifndef TRIANGLE_AREA_HERON_MACROS_SVH
`define TRIANGLE_AREA_HERON_MACROS_SVH

// Plain property under the block clock, muted during reset
`define TAH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define TAH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TAH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tah_pkg.sv
// Shared widths and defaults for the triangle area pipeline
package tah_pkg;

  localparam int SIDE_W        = 16;  // width of a side port
  localparam int AREA_W        = 31;  // width of the area port
  localparam int SIDE_BITS_DEF = 16;  // default number of side bits used

endpackage

### hdl/triangle_area_heron.sv
// Top level of the Heron triangle area pipeline
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------------------------------
//   input   | in        | in_valid_i / in_ready_o  | side_a_i, side_b_i, side_c_i
//   result  | out       | out_valid_o / out_ready_i| valid_res_o, area_quarter_o
//
// One word enters per cycle while in_ready_o is high; the pipeline has one check stage,
// three product stages and one root stage per result bit.
// Reset clears only the stage valid bits; the pipeline is empty after reset.
// A stall holds each full stage in place while empty stages ahead keep filling,
// so input is still taken while a finished result waits, as long as some stage is empty.
`include "triangle_area_heron_macros.svh"

module triangle_area_heron #(
  parameter int SIDE_BITS = tah_pkg::SIDE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tah_pkg::SIDE_W-1:0]  side_a_i,
  input  logic [tah_pkg::SIDE_W-1:0]  side_b_i,
  input  logic [tah_pkg::SIDE_W-1:0]  side_c_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        valid_res_o,
  output logic [tah_pkg::AREA_W-1:0]  area_quarter_o
);

  localparam int FW = SIDE_BITS + 1;
  localparam int RW = 2 * SIDE_BITS - 1;
  localparam int PW = 2 * RW;

  logic          fr_valid, fr_ready, fr_ok;
  logic [FW-1:0] f1, f2, f3, f4;
  logic          mu_valid, mu_ready, mu_ok;
  logic [PW-1:0] prod;
  logic          sq_ok;
  logic [RW-1:0] root;

  tah_front #(.SIDE_BITS(SIDE_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .side_a_i    (side_a_i),
    .side_b_i    (side_b_i),
    .side_c_i    (side_c_i),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .ok_o        (fr_ok),
    .f1_o        (f1),
    .f2_o        (f2),
    .f3_o        (f3),
    .f4_o        (f4)
  );

  tah_mult #(.SIDE_BITS(SIDE_BITS)) u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .ok_i        (fr_ok),
    .f1_i        (f1),
    .f2_i        (f2),
    .f3_i        (f3),
    .f4_i        (f4),
    .out_valid_o (mu_valid),
    .out_ready_i (mu_ready),
    .ok_o        (mu_ok),
    .prod_o      (prod)
  );

  tah_sqrt #(.SIDE_BITS(SIDE_BITS)) u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mu_valid),
    .in_ready_o  (mu_ready),
    .ok_i        (mu_ok),
    .prod_i      (prod),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ok_o        (sq_ok),
    .root_o      (root)
  );

  assign valid_res_o    = sq_ok;
  assign area_quarter_o = tah_pkg::AREA_W'(root);

  `TAH_ASSERT_IMPL(a_reject_zero, clk_i, rst_ni, out_valid_o && !valid_res_o, area_quarter_o == '0, "rejected triangle with nonzero area")
  `TAH_ASSERT_IMPL(a_accept_pos, clk_i, rst_ni, out_valid_o && valid_res_o, area_quarter_o != '0, "proper triangle with zero area")

endmodule

### hdl/tah_front.sv
// Input stage: side sign extension, triangle check and the four Heron factors
`include "triangle_area_heron_macros.svh"

module tah_front #(
  parameter int SIDE_BITS = tah_pkg::SIDE_BITS_DEF,
  localparam int FW = SIDE_BITS + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tah_pkg::SIDE_W-1:0]  side_a_i,
  input  logic [tah_pkg::SIDE_W-1:0]  side_b_i,
  input  logic [tah_pkg::SIDE_W-1:0]  side_c_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        ok_o,
  output logic [FW-1:0]               f1_o,
  output logic [FW-1:0]               f2_o,
  output logic [FW-1:0]               f3_o,
  output logic [FW-1:0]               f4_o
);

  localparam int XW = SIDE_BITS + 2;

  logic signed [XW-1:0] xa, xb, xc;
  logic signed [XW-1:0] s1, s2, s3, s4;
  logic                 pos, tri_ok;
  logic                 v_q;
  logic                 ok_q;
  logic [FW-1:0]        f1_q, f2_q, f3_q, f4_q;

  // use the low side bits only, sign-extended
  assign xa = {{2{side_a_i[SIDE_BITS-1]}}, side_a_i[SIDE_BITS-1:0]};
  assign xb = {{2{side_b_i[SIDE_BITS-1]}}, side_b_i[SIDE_BITS-1:0]};
  assign xc = {{2{side_c_i[SIDE_BITS-1]}}, side_c_i[SIDE_BITS-1:0]};

  assign s1 = xa + xb + xc;
  assign s2 = xb + xc - xa;
  assign s3 = xa + xc - xb;
  assign s4 = xa + xb - xc;

  assign pos    = !xa[XW-1] && (xa != '0) && !xb[XW-1] && (xb != '0)
               && !xc[XW-1] && (xc != '0);
  // strict inequality on every side is the same as every factor being positive
  assign tri_ok = pos && !s2[XW-1] && (s2 != '0) && !s3[XW-1] && (s3 != '0)
               && !s4[XW-1] && (s4 != '0);

  assign in_ready_o = !v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  // zero the factors of a rejected word so its root comes out zero
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ok_q <= tri_ok;
      f1_q <= tri_ok ? s1[FW-1:0] : '0;
      f2_q <= tri_ok ? s2[FW-1:0] : '0;
      f3_q <= tri_ok ? s3[FW-1:0] : '0;
      f4_q <= tri_ok ? s4[FW-1:0] : '0;
    end
  end

  assign out_valid_o = v_q;
  assign ok_o        = ok_q;
  assign f1_o        = f1_q;
  assign f2_o        = f2_q;
  assign f3_o        = f3_q;
  assign f4_o        = f4_q;

  `TAH_ASSERT_NEXT(a_front_load, clk_i, rst_ni, in_valid_i && in_ready_o, v_q, "front stage dropped an accepted word")

endmodule

### hdl/tah_mult.sv
// Product of the four factors in three stages: pair products, split partials, sum
module tah_mult #(
  parameter int SIDE_BITS = tah_pkg::SIDE_BITS_DEF,
  localparam int FW = SIDE_BITS + 1,
  localparam int PW = 4 * SIDE_BITS - 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          ok_i,
  input  logic [FW-1:0] f1_i,
  input  logic [FW-1:0] f2_i,
  input  logic [FW-1:0] f3_i,
  input  logic [FW-1:0] f4_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          ok_o,
  output logic [PW-1:0] prod_o
);

  localparam int MW = 2 * FW;
  localparam int QW = 3 * FW;
  localparam int SW = 4 * FW;

  logic [2:0]    v_q;
  logic [3:0]    rdy;
  logic [2:0]    ok_q;
  logic [MW-1:0] m12_q, m34_q;
  logic [QW-1:0] plo_q, phi_q;
  logic [SW-1:0] sum;
  logic [PW-1:0] prod_q;

  assign rdy[3] = out_ready_i;
  assign rdy[2] = !v_q[2] || rdy[3];
  assign rdy[1] = !v_q[1] || rdy[2];
  assign rdy[0] = !v_q[0] || rdy[1];
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
    end
  end

  // low bits of the sum only: the full product stays below 2^PW
  assign sum = SW'(plo_q) + (SW'(phi_q) << FW);

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      ok_q[0] <= ok_i;
      m12_q   <= MW'(f1_i) * MW'(f2_i);
      m34_q   <= MW'(f3_i) * MW'(f4_i);
    end
    if (rdy[1] && v_q[0]) begin
      ok_q[1] <= ok_q[0];
      plo_q   <= QW'(m12_q[FW-1:0]) * QW'(m34_q);
      phi_q   <= QW'(m12_q[MW-1:FW]) * QW'(m34_q);
    end
    if (rdy[2] && v_q[1]) begin
      ok_q[2] <= ok_q[1];
      prod_q  <= sum[PW-1:0];
    end
  end

  assign out_valid_o = v_q[2];
  assign ok_o        = ok_q[2];
  assign prod_o      = prod_q;

endmodule

### hdl/tah_sqrt.sv
// Integer square root, one result bit per pipeline stage
`include "triangle_area_heron_macros.svh"

module tah_sqrt #(
  parameter int SIDE_BITS = tah_pkg::SIDE_BITS_DEF,
  localparam int RW = 2 * SIDE_BITS - 1,
  localparam int PW = 2 * RW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          ok_i,
  input  logic [PW-1:0] prod_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          ok_o,
  output logic [RW-1:0] root_o
);

  logic [RW-1:0] v_q;
  logic [RW:0]   rdy;
  logic [RW-1:0] ok_q;
  logic [PW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];

  assign rdy[RW]    = out_ready_i;
  assign in_ready_o = rdy[0];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int BI = RW - 1 - k;

    logic          v_in, ok_in, ge;
    logic [PW-1:0] rem_in, trial;
    logic [RW-1:0] root_in;

    if (k == 0) begin : g_head
      assign v_in    = in_valid_i;
      assign ok_in   = ok_i;
      assign rem_in  = prod_i;
      assign root_in = '0;
    end else begin : g_body
      assign v_in    = v_q[k-1];
      assign ok_in   = ok_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign rdy[k] = !v_q[k] || rdy[k+1];

    // (r + 2^i)^2 - r^2 = r * 2^(i+1) + 2^(2i)
    assign trial = (PW'(root_in) << (BI + 1)) | (PW'(1) << (2 * BI));
    assign ge    = rem_in >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_in) begin
        ok_q[k]   <= ok_in;
        rem_q[k]  <= ge ? rem_in - trial : rem_in;
        root_q[k] <= root_in | (RW'(ge) << BI);
      end
    end
  end

  assign out_valid_o = v_q[RW-1];
  assign ok_o        = ok_q[RW-1];
  assign root_o      = root_q[RW-1];

  `TAH_ASSERT_NEXT(a_sqrt_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(root_o), "root stage lost a stalled word")

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the Heron triangle area pipeline: corner table, then random triangles
module testbench;

  localparam int SIDE_BITS = tah_pkg::SIDE_BITS_DEF;
  localparam int SIDE_W    = tah_pkg::SIDE_W;
  localparam int AREA_W    = tah_pkg::AREA_W;
  localparam int PIPE_LAT  = 2 * SIDE_BITS + 3;
  localparam int N_RANDOM  = 800;
  localparam int N_CORNERS = 20;

  typedef struct packed {
    logic              ok;
    logic [AREA_W-1:0] area;
  } heron_res_t;

  typedef struct packed {
    logic [SIDE_W-1:0] a;
    logic [SIDE_W-1:0] b;
    logic [SIDE_W-1:0] c;
    logic              known;
    heron_res_t        res;
  } corner_t;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [SIDE_W-1:0] side_a_i    = '0;
  logic [SIDE_W-1:0] side_b_i    = '0;
  logic [SIDE_W-1:0] side_c_i    = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              valid_res_o;
  logic [AREA_W-1:0] area_quarter_o;

  heron_res_t area_expect_q[$];
  int         n_errors  = 0;
  int         n_sent    = 0;
  int         n_proper  = 0;
  int         n_results = 0;
  bit         tx_calm   = 1'b0;
  bit         rx_calm   = 1'b0;

  // Expected area is typed in where it is plain; the rest goes through the predictor
  corner_t corners [N_CORNERS] = '{
    '{16'h0003, 16'h0004, 16'h0005, 1'b1, '{1'b1, 31'd24}},
    '{16'h0001, 16'h0001, 16'h0001, 1'b1, '{1'b1, 31'd1}},
    '{16'h0000, 16'h0000, 16'h0000, 1'b1, '{1'b0, 31'd0}},
    '{16'h0000, 16'h0005, 16'h0005, 1'b1, '{1'b0, 31'd0}},
    '{16'hFFFF, 16'h0005, 16'h0005, 1'b1, '{1'b0, 31'd0}},
    '{16'h8000, 16'h8000, 16'h8000, 1'b1, '{1'b0, 31'd0}},
    '{16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '{1'b0, 31'd0}},
    '{16'h0001, 16'h0002, 16'h0003, 1'b1, '{1'b0, 31'd0}},
    '{16'h0005, 16'h0002, 16'h0003, 1'b1, '{1'b0, 31'd0}},
    '{16'h0002, 16'h0005, 16'h0003, 1'b1, '{1'b0, 31'd0}},
    '{16'h0001, 16'h0001, 16'h0002, 1'b1, '{1'b0, 31'd0}},
    '{16'h7FFF, 16'h7FFF, 16'h0001, 1'b0, '{1'b0, 31'd0}},
    '{16'h7FFF, 16'h0001, 16'h7FFF, 1'b0, '{1'b0, 31'd0}},
    '{16'h0001, 16'h7FFF, 16'h7FFF, 1'b0, '{1'b0, 31'd0}},
    '{16'h7FFF, 16'h7FFE, 16'h0001, 1'b1, '{1'b0, 31'd0}},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, '{1'b0, 31'd0}},
    '{16'h0002, 16'h0002, 16'h0003, 1'b0, '{1'b0, 31'd0}},
    '{16'h7FFF, 16'h8000, 16'h7FFF, 1'b1, '{1'b0, 31'd0}},
    '{16'h000A, 16'h000A, 16'h0013, 1'b0, '{1'b0, 31'd0}},
    '{16'h4000, 16'h4000, 16'h7FFF, 1'b0, '{1'b0, 31'd0}}
  };

  triangle_area_heron #(
    .SIDE_BITS(SIDE_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .side_a_i      (side_a_i),
    .side_b_i      (side_b_i),
    .side_c_i      (side_c_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .valid_res_o   (valid_res_o),
    .area_quarter_o(area_quarter_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Keep the low SIDE_BITS bits and sign-extend from the top one
  function automatic int side_value_of(logic [SIDE_W-1:0] raw);
    int v;
    v = int'({16'd0, raw}) & ((1 << SIDE_BITS) - 1);
    if (v[SIDE_BITS-1]) v = v - (1 << SIDE_BITS);
    return v;
  endfunction

  function automatic heron_res_t heron_area(logic [SIDE_W-1:0] ra, logic [SIDE_W-1:0] rb,
                                            logic [SIDE_W-1:0] rc);
    int                a, b, c;
    longint unsigned   f1, f2, f3, f4, prod, root, cand;
    heron_res_t        r;
    a = side_value_of(ra);
    b = side_value_of(rb);
    c = side_value_of(rc);
    r.ok   = 1'b0;
    r.area = '0;
    if (a > 0 && b > 0 && c > 0 && a + b > c && a + c > b && b + c > a) begin
      f1   = longint'(a + b + c);
      f2   = longint'(b + c - a);
      f3   = longint'(a + c - b);
      f4   = longint'(a + b - c);
      prod = f1 * f2 * f3 * f4;
      // Build the floor root one bit at a time from the top
      root = 0;
      for (int i = 31; i >= 0; i--) begin
        cand = root | (64'd1 << i);
        if (cand * cand <= prod) root = cand;
      end
      r.ok   = 1'b1;
      r.area = root[AREA_W-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    n_errors++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic make_sides(output logic [SIDE_W-1:0] sa, output logic [SIDE_W-1:0] sb,
                            output logic [SIDE_W-1:0] sc);
    int a, b, c, lim, kind, lo, hi;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0:       lim = 15;
      1:       lim = 255;
      default: lim = 32767;
    endcase
    a  = $urandom_range(1, lim);
    b  = $urandom_range(1, lim);
    lo = (a > b) ? a - b : b - a;
    hi = (a + b - 1 < 32767) ? a + b - 1 : 32767;
    if (kind < 60) begin
      c = $urandom_range(lo + 1, hi);
    end else if (kind < 75) begin
      // Flat triangle: one side equals the sum or difference of the others
      c = (kind[0] && a + b <= 32767) ? a + b : lo;
    end else if (kind < 85) begin
      c = -int'($urandom_range(0, 32768));
    end else begin
      a = $urandom;
      b = $urandom;
      c = $urandom;
    end
    case ($urandom_range(0, 2))
      0:       begin sa = 16'(a); sb = 16'(b); sc = 16'(c); end
      1:       begin sa = 16'(c); sb = 16'(a); sc = 16'(b); end
      default: begin sa = 16'(b); sb = 16'(c); sc = 16'(a); end
    endcase
  endtask

  task automatic send_word(input logic [SIDE_W-1:0] a, input logic [SIDE_W-1:0] b,
                           input logic [SIDE_W-1:0] c, input heron_res_t want);
    int gap;
    if (n_sent % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    side_a_i   <= a;
    side_b_i   <= b;
    side_c_i   <= c;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    area_expect_q.push_back(want);
    n_sent++;
    if (want.ok) n_proper++;
  endtask

  // Drop valid and hold off until the pipeline has handed back every word
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (area_expect_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin : result_sink
    int         stall;
    heron_res_t want;
    @(posedge rst_ni);
    forever begin
      if (n_results % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      stall = rx_calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      n_results++;
      if (area_expect_q.size() == 0) begin
        report_mismatch($sformatf("result word with nothing pending: valid=%b area=%0d",
                                  valid_res_o, area_quarter_o));
      end else begin
        want = area_expect_q.pop_front();
        if (valid_res_o !== want.ok)
          report_mismatch($sformatf("valid_res: got %b, want %b", valid_res_o, want.ok));
        if (area_quarter_o !== want.area)
          report_mismatch($sformatf("area_quarter: got %0d, want %0d",
                                    area_quarter_o, want.area));
      end
    end
  end

  initial begin : word_source
    logic [SIDE_W-1:0] ra, rb, rc;
    heron_res_t        want;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_CORNERS; i++) begin
      want = corners[i].known ? corners[i].res :
             heron_area(corners[i].a, corners[i].b, corners[i].c);
      send_word(corners[i].a, corners[i].b, corners[i].c, want);
    end
    drain_results();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) drain_results();
      make_sides(ra, rb, rc);
      send_word(ra, rb, rc, heron_area(ra, rb, rc));
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (area_expect_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 8) @(posedge clk_i);

    $display("Ran %0d side triples (%0d proper triangles), %0d result words checked,",
             n_sent, n_proper, n_results);
    $display("with random gaps and stalls on both sides and two full drains mid-run.");
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Timed out with %0d result words still pending.", area_expect_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
